// ===== rtl/core/slkpd_pkg.sv =====
package slkpd_pkg;

  localparam int NUM_BUTTONS = 6;
  localparam int TICKS_W     = 16;
  localparam int IDX_W       = 3;

  localparam logic [TICKS_W-1:0] LONG_TICKS_RST  = 16'd7800;
  localparam logic [TICKS_W-1:0] SHORT_TICKS_RST = 16'd800;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_LONG_PRESS_TICKS  = 1'b0,
    CFG_SHORT_PRESS_TICKS = 1'b1
  } cfg_idx_t;

  typedef logic [NUM_BUTTONS-1:0] btn_vec_t;
  typedef logic [TICKS_W-1:0]     ticks_t;

  // one result transaction
  typedef struct packed {
    logic             event_valid;
    logic [IDX_W-1:0] button_index;
    logic             is_long;
  } scan_res_t;

  // per-step state shared between the top level and the scanner
  typedef struct packed {
    btn_vec_t locked;
    btn_vec_t pending;
    ticks_t   countdown;
  } scan_state_t;

endpackage

// ===== rtl/core/slkpd_in_if.sv =====
interface slkpd_in_if;
  logic                                valid;
  logic                                ready;
  logic [slkpd_pkg::NUM_BUTTONS-1:0]   buttons_n;
  logic                                tick;

  modport source (output valid, output buttons_n, output tick, input ready);
  modport sink   (input valid, input buttons_n, input tick, output ready);
endinterface

// ===== rtl/core/slkpd_out_if.sv =====
interface slkpd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          event_valid;
  logic [slkpd_pkg::IDX_W-1:0]   button_index;
  logic                          is_long;

  modport source (output valid, output event_valid, output button_index, output is_long,
                  input ready);
  modport sink   (input valid, input event_valid, input button_index, input is_long,
                  output ready);
endinterface

// ===== rtl/core/slkpd_scan.sv =====
module slkpd_scan (
  input  slkpd_pkg::scan_state_t cur,
  input  slkpd_pkg::btn_vec_t    buttons_n,
  input  logic                   tick,
  input  slkpd_pkg::ticks_t      long_ticks,
  input  slkpd_pkg::ticks_t      short_ticks,
  output slkpd_pkg::scan_state_t nxt,
  output slkpd_pkg::scan_res_t   res
);
  import slkpd_pkg::*;

  ticks_t             cd_dec;
  logic               cd_zero;
  logic               unlock_ok;
  btn_vec_t           pressed;
  logic               hit;
  logic [TICKS_W:0]   rel_sum;

  // saturating tick decrement ahead of the scan
  assign cd_dec    = (tick && (cur.countdown != '0)) ? cur.countdown - 1'b1 : cur.countdown;
  assign cd_zero   = (cd_dec == '0);
  assign rel_sum   = {1'b0, cd_dec} + {1'b0, short_ticks};
  assign unlock_ok = (rel_sum < {1'b0, long_ticks});
  assign pressed   = ~buttons_n;

  // priority scan, stops at the first event
  always_comb begin
    nxt           = cur;
    nxt.countdown = cd_dec;
    res           = '0;
    hit           = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (!hit) begin
        if (!cur.locked[i] && pressed[i]) begin
          nxt.locked[i]    = 1'b1;
          nxt.pending[i]   = 1'b1;
          nxt.countdown    = long_ticks;
          res.event_valid  = 1'b1;
          res.button_index = IDX_W'(i);
          res.is_long      = 1'b0;
          hit              = 1'b1;
        end else if (!pressed[i] && cur.locked[i]) begin
          if (unlock_ok) begin
            nxt.locked[i]  = 1'b0;
            nxt.pending[i] = 1'b0;
          end
        end else if (cur.pending[i] && cd_zero) begin
          nxt.pending[i]   = 1'b0;
          res.event_valid  = 1'b1;
          res.button_index = IDX_W'(i);
          res.is_long      = 1'b1;
          hit              = 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/short_long_key_press_detector.sv =====
// channel  | dir | payload                              | handshake
// ---------+-----+--------------------------------------+-------------
// in_chan  | in  | buttons_n[5:0], tick                 | valid/ready
// out_chan | out | event_valid, button_index[2:0], is_long | valid/ready
// cfg_*    | in  | cfg_index (register), cfg_wdata[15:0] | cfg_we only
//
// one result transaction per input transaction, one transaction per cycle sustained while the output is not stalled
// path: input register, then scan logic into the result register
// the scan and the state update happen in the same cycle, the state feedback loop sets the rate
// rst_n is synchronous, active low: clears state, valid flags and restores register defaults
// a stalled output keeps its result; the input register still takes one more transaction
module short_long_key_press_detector (
  input  logic                  clk,
  input  logic                  rst_n,
  slkpd_in_if.sink              in_chan,
  slkpd_out_if.source           out_chan,
  input  logic                  cfg_we,
  input  slkpd_pkg::cfg_idx_t   cfg_index,
  input  slkpd_pkg::ticks_t     cfg_wdata
);
  import slkpd_pkg::*;

  // configuration registers
  ticks_t      long_ticks_r;
  ticks_t      short_ticks_r;

  // input register stage
  logic        s1_valid_r;
  btn_vec_t    s1_buttons_n_r;
  logic        s1_tick_r;
  logic        s1_adv;

  // detector state
  scan_state_t state_r;
  scan_state_t state_nxt;
  scan_res_t   res_nxt;

  // result register
  logic        out_valid_r;
  scan_res_t   out_res_r;

  // the scan stage moves on whenever the result slot is free or being drained
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r  <= LONG_TICKS_RST;
      short_ticks_r <= SHORT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LONG_PRESS_TICKS:  long_ticks_r  <= cfg_wdata;
        CFG_SHORT_PRESS_TICKS: short_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_buttons_n_r <= in_chan.buttons_n;
      s1_tick_r      <= in_chan.tick;
    end
  end

  // tick, priority scan and next state for the transaction in the input register
  slkpd_scan u_scan (
    .cur         (state_r),
    .buttons_n   (s1_buttons_n_r),
    .tick        (s1_tick_r),
    .long_ticks  (long_ticks_r),
    .short_ticks (short_ticks_r),
    .nxt         (state_nxt),
    .res         (res_nxt)
  );

  // state only moves when the transaction is committed to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.event_valid  = out_res_r.event_valid;
  assign out_chan.button_index = out_res_r.button_index;
  assign out_chan.is_long      = out_res_r.is_long;

`ifndef SYNTHESIS
  // an armed long detection always belongs to a locked button
  a_pending_locked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.pending & ~state_r.locked) == '0)
    else $error("long detection armed on an unlocked button");

  // a short event reloads the countdown with the long press time
  a_short_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res_nxt.event_valid && !res_nxt.is_long)
      |=> (state_r.countdown == $past(long_ticks_r)))
    else $error("countdown not loaded on a short event");

  // without a short event the countdown never rises
  a_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv && res_nxt.event_valid && !res_nxt.is_long)
      |=> (state_r.countdown <= $past(state_r.countdown)))
    else $error("countdown rose without a press");
`endif

endmodule
